@@ hdl/assert_macros.svh @@
// assertion macros used by the frame sampler rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define YCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define YCR_ASSERT_NEVER(label, cond, msg) \
  `YCR_ASSERT(label, !(cond), msg)

`endif

@@ hdl/ycr_pkg.sv @@
// shared types and constants of the yuv420 crop and resample block
// no dependencies
`default_nettype none

package ycr_pkg;

  // field widths fixed by the block interface
  localparam int ADDR_W = 15;
  localparam int GRID_W = 8;

  typedef logic [7:0] byte_t;

  // register map, one word per register
  typedef enum logic [1:0] {
    REG_ROI_LEFT   = 2'd0,
    REG_ROI_TOP    = 2'd1,
    REG_ROI_SPAN_X = 2'd2,
    REG_ROI_SPAN_Y = 2'd3
  } reg_idx_e;

  // register reset values
  localparam logic [7:0] ROI_LEFT_RST   = 8'd32;
  localparam logic [6:0] ROI_TOP_RST    = 7'd12;
  localparam logic [7:0] ROI_SPAN_X_RST = 8'd96;
  localparam logic [7:0] ROI_SPAN_Y_RST = 8'd96;

  // integer bt.601 coefficients
  localparam logic signed [17:0] Y_GAIN  = 18'sd298;
  localparam logic signed [17:0] RV_GAIN = 18'sd409;
  localparam logic signed [17:0] GU_GAIN = 18'sd100;
  localparam logic signed [17:0] GV_GAIN = 18'sd208;
  localparam logic signed [17:0] BU_GAIN = 18'sd516;
  localparam logic signed [9:0]  Y_OFS   = 10'sd16;
  localparam logic signed [9:0]  C_OFS   = 10'sd128;
  localparam logic signed [19:0] ROUND   = 20'sd128;

  // stage enables of one axis mapper
  typedef struct packed {
    logic mul;
    logic scale;
    logic clamp;
  } map_en_t;

  // stage enables of the color converter
  typedef struct packed {
    logic prod;
    logic res;
  } csc_en_t;

endpackage

`default_nettype wire

@@ hdl/ycr_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module ycr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read share the one port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/ycr_axis_map.sv @@
// maps one output grid index to a clamped source coordinate, three stages
// depends on ycr_pkg
`default_nettype none

module ycr_axis_map #(
  parameter int LIMIT    = 160,
  parameter int OUT_SIZE = 256
) (
  input  wire logic                       clk_i,
  input  wire ycr_pkg::map_en_t           en_i,
  input  wire logic [7:0]                 idx_i,
  input  wire logic [7:0]                 span_i,
  input  wire logic [7:0]                 origin_i,
  output logic      [$clog2(LIMIT)-1:0]   coord_o
);

  // divide by 2*OUT_SIZE through an exact reciprocal
  localparam int PW = ycr_pkg::GRID_W + 9;
  localparam int Div = 2 * OUT_SIZE;
  localparam int DW = $clog2(Div);
  localparam int K = PW + DW;
  localparam int MW = PW + 2;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'(Div) - 64'd1) / 64'(Div));
  localparam int QW = PW + MW - K;
  localparam int SW = ((QW > 8) ? QW : 8) + 1;
  localparam int CW = $clog2(LIMIT);

  logic [PW-1:0]    prod_q;
  logic [QW-1:0]    quot_q;
  logic [CW-1:0]    coord_q;
  logic [PW+MW-1:0] scaled;
  logic [SW-1:0]    pos;

  // pixel centre times span
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= PW'({idx_i, 1'b1}) * PW'(span_i);
    end
  end

  // quotient by the grid size
  assign scaled = (PW + MW)'(prod_q) * (PW + MW)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.scale) begin
      quot_q <= scaled[K +: QW];
    end
  end

  // add region origin and clamp to the frame
  assign pos = SW'(origin_i) + SW'(quot_q);

  always_ff @(posedge clk_i) begin
    if (en_i.clamp) begin
      if (32'(pos) > 32'(LIMIT - 1)) begin
        coord_q <= CW'(LIMIT - 1);
      end else begin
        coord_q <= CW'(pos);
      end
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

@@ hdl/ycr_csc.sv @@
// bt.601 yuv to rgb conversion, product stage then sum and clamp stage
// depends on ycr_pkg
`default_nettype none

module ycr_csc (
  input  wire logic            clk_i,
  input  wire ycr_pkg::csc_en_t en_i,
  input  wire ycr_pkg::byte_t  y_i,
  input  wire ycr_pkg::byte_t  u_i,
  input  wire ycr_pkg::byte_t  v_i,
  output ycr_pkg::byte_t       red_o,
  output ycr_pkg::byte_t       green_o,
  output ycr_pkg::byte_t       blue_o
);

  logic signed [9:0]  c_val, d_val, e_val;
  logic signed [17:0] yc_q, rv_q, gu_q, gv_q, bu_q;
  logic signed [19:0] r_sum, g_sum, b_sum;
  ycr_pkg::byte_t     red_q, green_q, blue_q;

  // floor by 256 and clamp to a byte
  function automatic ycr_pkg::byte_t sat_byte(input logic signed [19:0] s);
    ycr_pkg::byte_t res;
    if (s < 0) begin
      res = 8'd0;
    end else if (s[19:16] != 4'd0) begin
      res = 8'd255;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  // offsets from the nominal black and gray levels
  assign c_val = $signed({2'b00, y_i}) - ycr_pkg::Y_OFS;
  assign d_val = $signed({2'b00, u_i}) - ycr_pkg::C_OFS;
  assign e_val = $signed({2'b00, v_i}) - ycr_pkg::C_OFS;

  // coefficient products
  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      yc_q <= ycr_pkg::Y_GAIN * 18'(c_val);
      rv_q <= ycr_pkg::RV_GAIN * 18'(e_val);
      gu_q <= ycr_pkg::GU_GAIN * 18'(d_val);
      gv_q <= ycr_pkg::GV_GAIN * 18'(e_val);
      bu_q <= ycr_pkg::BU_GAIN * 18'(d_val);
    end
  end

  // channel sums with rounding
  assign r_sum = 20'(yc_q) + 20'(rv_q) + ycr_pkg::ROUND;
  assign g_sum = 20'(yc_q) - 20'(gu_q) - 20'(gv_q) + ycr_pkg::ROUND;
  assign b_sum = 20'(yc_q) + 20'(bu_q) + ycr_pkg::ROUND;

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      red_q   <= sat_byte(r_sum);
      green_q <= sat_byte(g_sum);
      blue_q  <= sat_byte(b_sum);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

@@ hdl/yuv420_crop_resample_to_rgb.sv @@
// Frame store with nearest-neighbour crop-and-resize to RGB. One word enters
// per cycle, a frame byte load or a pixel request, and a request passes the
// input register, three mapping stages, address stage, ram read, product
// stage and output register. Loads and reads go through the same single
// port of each plane ram at the address stage, so every request sees
// exactly the loads taken before it and one word per cycle is the sustained
// rate. Every stage holds when its successor is full; an output word waiting
// on out_stall_i does not stop the stages behind it from filling. The planes
// are not cleared: read only pixels that were loaded. The user writes region
// registers over the apb port while idle; the block does not enforce it.
// depends on ycr_pkg, ycr_ram, ycr_axis_map, ycr_csc and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module yuv420_crop_resample_to_rgb #(
  parameter int FRAME_WIDTH  = 160,
  parameter int FRAME_HEIGHT = 120,
  parameter int OUT_SIZE     = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         op_i,
  input  wire logic [ycr_pkg::ADDR_W-1:0]   load_addr_i,
  input  wire ycr_pkg::byte_t               load_byte_i,
  input  wire logic [ycr_pkg::GRID_W-1:0]   out_col_i,
  input  wire logic [ycr_pkg::GRID_W-1:0]   out_row_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ycr_pkg::byte_t                    red_o,
  output ycr_pkg::byte_t                    green_o,
  output ycr_pkg::byte_t                    blue_o,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int LUMA_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CHROMA_W    = FRAME_WIDTH / 2;
  localparam int CHROMA_H    = FRAME_HEIGHT / 2;
  localparam int CHROMA_SIZE = CHROMA_W * CHROMA_H;
  localparam int YAW = (LUMA_SIZE > 1) ? $clog2(LUMA_SIZE) : 1;
  localparam int CAW = (CHROMA_SIZE > 1) ? $clog2(CHROMA_SIZE) : 1;
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);

  // word carried alongside the mapping stages
  typedef struct packed {
    logic              req;
    logic              wy;
    logic              wu;
    logic              wv;
    logic [YAW-1:0]    ya;
    logic [CAW-1:0]    ca;
    ycr_pkg::byte_t    data;
  } item_t;

  logic [7:0] roi_left_q, span_x_q, span_y_q;
  logic [6:0] roi_top_q;
  logic       cfg_wr;

  logic [7:1] vld_q;
  logic [7:1] adv;
  logic       out_vld_q;
  logic       adv_out;

  logic                       op1_q;
  logic [ycr_pkg::ADDR_W-1:0] addr1_q;
  ycr_pkg::byte_t             byte1_q;
  logic [ycr_pkg::GRID_W-1:0] col1_q, row1_q;

  item_t item2_d, item2_q, item3_q, item4_q, item5_d, item5_q;

  logic [31:0] la, u_rel, v_rel, cx32, cy32;
  logic        is_y, is_u, is_v;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic          we_y, we_u, we_v;
  ycr_pkg::byte_t y_rd, u_rd, v_rd;

  // register writes
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_left_q <= ycr_pkg::ROI_LEFT_RST;
      roi_top_q  <= ycr_pkg::ROI_TOP_RST;
      span_x_q   <= ycr_pkg::ROI_SPAN_X_RST;
      span_y_q   <= ycr_pkg::ROI_SPAN_Y_RST;
    end else if (cfg_wr) begin
      case (ycr_pkg::reg_idx_e'(paddr[3:2]))
        ycr_pkg::REG_ROI_LEFT:   roi_left_q <= pwdata[7:0];
        ycr_pkg::REG_ROI_TOP:    roi_top_q  <= pwdata[6:0];
        ycr_pkg::REG_ROI_SPAN_X: span_x_q   <= pwdata[7:0];
        ycr_pkg::REG_ROI_SPAN_Y: span_y_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ycr_pkg::reg_idx_e'(paddr[3:2]))
      ycr_pkg::REG_ROI_LEFT:   prdata = 32'(roi_left_q);
      ycr_pkg::REG_ROI_TOP:    prdata = 32'(roi_top_q);
      ycr_pkg::REG_ROI_SPAN_X: prdata = 32'(span_x_q);
      ycr_pkg::REG_ROI_SPAN_Y: prdata = 32'(span_y_q);
      default:                 prdata = 32'd0;
    endcase
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    adv_out = !out_vld_q || !out_stall_i;
    adv[7]  = !vld_q[7] || adv_out;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv[1]) vld_q[1] <= in_valid_i;
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
      if (adv[4]) vld_q[4] <= vld_q[3];
      if (adv[5]) vld_q[5] <= vld_q[4];
      if (adv[6]) vld_q[6] <= vld_q[5] && item5_q.req;
      if (adv[7]) vld_q[7] <= vld_q[6];
      if (adv_out) out_vld_q <= vld_q[7];
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      op1_q   <= op_i;
      addr1_q <= load_addr_i;
      byte1_q <= load_byte_i;
      col1_q  <= out_col_i;
      row1_q  <= out_row_i;
    end
  end

  // load address decode into plane and offset
  always_comb begin
    la    = 32'(addr1_q);
    u_rel = la - 32'(LUMA_SIZE);
    v_rel = u_rel - 32'(CHROMA_SIZE);
    is_y  = la < 32'(LUMA_SIZE);
    is_u  = !is_y && (u_rel < 32'(CHROMA_SIZE));
    is_v  = !is_y && !is_u && (v_rel < 32'(CHROMA_SIZE));
    item2_d.req  = op1_q;
    item2_d.wy   = !op1_q && is_y;
    item2_d.wu   = !op1_q && is_u;
    item2_d.wv   = !op1_q && is_v;
    item2_d.ya   = YAW'(la);
    item2_d.ca   = is_u ? CAW'(u_rel) : CAW'(v_rel);
    item2_d.data = byte1_q;
  end

  // side band through the mapping stages
  always_ff @(posedge clk_i) begin
    if (adv[2]) item2_q <= item2_d;
    if (adv[3]) item3_q <= item2_q;
    if (adv[4]) item4_q <= item3_q;
    if (adv[5]) item5_q <= item5_d;
  end

  // grid to source coordinates
  ycr_axis_map #(
    .LIMIT    (FRAME_WIDTH),
    .OUT_SIZE (OUT_SIZE)
  ) u_map_x (
    .clk_i    (clk_i),
    .en_i     ('{mul: adv[2], scale: adv[3], clamp: adv[4]}),
    .idx_i    (col1_q),
    .span_i   (span_x_q),
    .origin_i (roi_left_q),
    .coord_o  (sx)
  );

  ycr_axis_map #(
    .LIMIT    (FRAME_HEIGHT),
    .OUT_SIZE (OUT_SIZE)
  ) u_map_y (
    .clk_i    (clk_i),
    .en_i     ('{mul: adv[2], scale: adv[3], clamp: adv[4]}),
    .idx_i    (row1_q),
    .span_i   (span_y_q),
    .origin_i ({1'b0, roi_top_q}),
    .coord_o  (sy)
  );

  // plane addresses for a request, load offsets pass unchanged
  always_comb begin
    cx32 = 32'(sx) >> 1;
    cy32 = 32'(sy) >> 1;
    if (cx32 > 32'(CHROMA_W - 1)) cx32 = 32'(CHROMA_W - 1);
    if (cy32 > 32'(CHROMA_H - 1)) cy32 = 32'(CHROMA_H - 1);
    item5_d = item4_q;
    if (item4_q.req) begin
      item5_d.ya = YAW'(32'(sy) * 32'(FRAME_WIDTH) + 32'(sx));
      item5_d.ca = CAW'(cy32 * 32'(CHROMA_W) + cx32);
    end
  end

  // plane stores, written and read in word order at the address stage
  assign we_y = vld_q[5] && item5_q.wy && adv[6];
  assign we_u = vld_q[5] && item5_q.wu && adv[6];
  assign we_v = vld_q[5] && item5_q.wv && adv[6];

  ycr_ram #(.WIDTH(8), .DEPTH(LUMA_SIZE)) u_luma (
    .clk_i   (clk_i),
    .we_i    (we_y),
    .re_i    (adv[6]),
    .addr_i  (item5_q.ya),
    .wdata_i (item5_q.data),
    .rdata_o (y_rd)
  );

  ycr_ram #(.WIDTH(8), .DEPTH(CHROMA_SIZE)) u_chroma_u (
    .clk_i   (clk_i),
    .we_i    (we_u),
    .re_i    (adv[6]),
    .addr_i  (item5_q.ca),
    .wdata_i (item5_q.data),
    .rdata_o (u_rd)
  );

  ycr_ram #(.WIDTH(8), .DEPTH(CHROMA_SIZE)) u_chroma_v (
    .clk_i   (clk_i),
    .we_i    (we_v),
    .re_i    (adv[6]),
    .addr_i  (item5_q.ca),
    .wdata_i (item5_q.data),
    .rdata_o (v_rd)
  );

  // color conversion and output register
  ycr_csc u_csc (
    .clk_i   (clk_i),
    .en_i    ('{prod: adv[7], res: adv_out}),
    .y_i     (y_rd),
    .u_i     (u_rd),
    .v_i     (v_rd),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  assign out_valid_o = out_vld_q;

  // input is held back only when every stage is full
  `YCR_ASSERT_NEVER(a_stall_with_bubble, in_stall_o && !((&vld_q) && out_vld_q),
    "input stalled while a pipeline stage is empty")
  // a load reaches at most one plane
  `YCR_ASSERT(a_one_plane, $onehot0({we_y, we_u, we_v}),
    "load written to more than one plane")
  // a result appears only after the product stage held a request
  `YCR_ASSERT(a_out_from_prod, $rose(out_valid_o) |-> $past(vld_q[7]),
    "result valid without a request in the product stage")
  // an accepted word lands in the input register
  `YCR_ASSERT(a_accept_lands, (in_valid_i && !in_stall_o) |=> vld_q[1],
    "accepted word lost at the input register")

endmodule

`default_nettype wire
